// ===== rtl/gru_pkg.sv =====
// Shared types and constants of the Givens rotation unit.
package gru_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned SqrtN   = 32;  // result bits of the square root
  localparam int unsigned QuoW    = 31;  // result bits of each divider lane
  localparam int unsigned FracQ30 = 30;

  localparam logic signed [WordW-1:0] OneQ30    = 32'sh4000_0000;
  localparam logic signed [WordW-1:0] NegOneQ30 = -32'sh4000_0000;

  localparam logic OpApply    = 1'b0;
  localparam logic OpGenerate = 1'b1;

  // Item data carried alongside the square root and divider pipes.
  typedef struct packed {
    logic                    op;
    logic signed [WordW-1:0] x;
    logic signed [WordW-1:0] y;
    logic signed [WordW-1:0] cc;    // clamped cosine for apply
    logic signed [WordW-1:0] sc;    // clamped sine for apply
    logic                    csat;  // clamp hit on apply
    logic                    yzero;
    logic                    gt;    // |y| > |x|
    logic [WordW-1:0]        a_n;   // normalized |x|
    logic [WordW-1:0]        b_n;   // normalized |y|
  } side_t;

endpackage

// ===== rtl/gru_front.sv =====
// Input stages: clamp, magnitudes, normalization and sum of squares.
module gru_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                op_i,
  input  logic [31:0]         x_i,
  input  logic [31:0]         y_i,
  input  logic [31:0]         cos_i,
  input  logic [31:0]         sin_i,
  output logic                valid_o,
  output gru_pkg::side_t      side_o,
  output logic [63:0]         rad_o
);
  import gru_pkg::*;

  logic              v1_q, v2_q, v3_q, v4_q;
  side_t             s1_d, s1_q, s2_d, s2_q, s3_q, s4_q;
  logic [ProdW-1:0]  aa_q, bb_q, rad_q;
  logic [WordW-1:0]  m;
  logic [4:0]        sh;

  always_comb begin
    s1_d       = '0;
    s1_d.op    = op_i;
    s1_d.x     = x_i;
    s1_d.y     = y_i;
    s1_d.csat  = 1'b0;
    s1_d.cc    = cos_i;
    s1_d.sc    = sin_i;
    if ($signed(cos_i) > OneQ30) begin
      s1_d.cc = OneQ30; s1_d.csat = 1'b1;
    end else if ($signed(cos_i) < NegOneQ30) begin
      s1_d.cc = NegOneQ30; s1_d.csat = 1'b1;
    end
    if ($signed(sin_i) > OneQ30) begin
      s1_d.sc = OneQ30; s1_d.csat = 1'b1;
    end else if ($signed(sin_i) < NegOneQ30) begin
      s1_d.sc = NegOneQ30; s1_d.csat = 1'b1;
    end
    s1_d.a_n   = x_i[31] ? (~x_i + 32'd1) : x_i;
    s1_d.b_n   = y_i[31] ? (~y_i + 32'd1) : y_i;
    s1_d.yzero = (y_i == '0);
    s1_d.gt    = s1_d.b_n > s1_d.a_n;
  end

  // Shift both magnitudes until the larger one is at least 2^30.
  always_comb begin
    m  = s1_q.gt ? s1_q.b_n : s1_q.a_n;
    sh = 5'd31;
    for (int i = 0; i < 31; i++) begin
      if (m[i]) sh = 5'(30 - i);
    end
    if (m[31]) sh = 5'd0;
    s2_d     = s1_q;
    s2_d.a_n = s1_q.a_n << sh;
    s2_d.b_n = s1_q.b_n << sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s2_q;
      aa_q  <= s2_q.a_n * s2_q.a_n;
      bb_q  <= s2_q.b_n * s2_q.b_n;
      s4_q  <= s3_q;
      rad_q <= aa_q + bb_q;
    end
  end

  assign valid_o = v4_q;
  assign side_o  = s4_q;
  assign rad_o   = rad_q;

endmodule

// ===== rtl/gru_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module gru_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  gru_pkg::side_t  side_i,
  input  logic [63:0]     rad_i,
  output logic            valid_o,
  output gru_pkg::side_t  side_o,
  output logic [31:0]     root_o
);
  import gru_pkg::*;

  logic              vld_q  [SqrtN];
  side_t             side_q [SqrtN];
  logic [35:0]       rem_q  [SqrtN];
  logic [35:0]       rem_d  [SqrtN];
  logic [SqrtN-1:0]  root_q [SqrtN];
  logic [SqrtN-1:0]  root_d [SqrtN];
  logic [ProdW-1:0]  rad_q  [SqrtN];
  logic [ProdW-1:0]  rad_d  [SqrtN];

  always_comb begin
    logic [35:0]      r_in, r_sh, trial;
    logic [SqrtN-1:0] q_in;
    logic [ProdW-1:0] n_in;
    for (int k = 0; k < SqrtN; k++) begin
      r_in  = (k == 0) ? '0 : rem_q[k-1];
      q_in  = (k == 0) ? '0 : root_q[k-1];
      n_in  = (k == 0) ? rad_i : rad_q[k-1];
      r_sh  = {r_in[33:0], n_in[63:62]};
      trial = {2'b00, q_in, 2'b01};
      rad_d[k] = {n_in[61:0], 2'b00};
      if (r_sh >= trial) begin
        rem_d[k]  = r_sh - trial;
        root_d[k] = {q_in[SqrtN-2:0], 1'b1};
      end else begin
        rem_d[k]  = r_sh;
        root_d[k] = {q_in[SqrtN-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtN; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < SqrtN; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < SqrtN; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < SqrtN; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign valid_o = vld_q[SqrtN-1];
  assign side_o  = side_q[SqrtN-1];
  assign root_o  = root_q[SqrtN-1];

endmodule

// ===== rtl/gru_div.sv =====
// Two-lane pipelined divider for cosine and sine, then sign and special cases.
module gru_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  gru_pkg::side_t      side_i,
  input  logic [31:0]         root_i,
  output logic                valid_o,
  output gru_pkg::side_t      side_o,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o
);
  import gru_pkg::*;

  localparam int unsigned NumW = 63;

  // Setup stage: numerators with half the divisor added for rounding.
  logic              v0_q;
  side_t             s0_q;
  logic [WordW-1:0]  h0_q;
  logic [WordW-1:0]  remc0_q, rems0_q;
  logic [QuoW-1:0]   lowc0_q, lows0_q;
  logic [NumW-1:0]   numc, nums;

  always_comb begin
    numc = {1'b0, side_i.a_n, 30'd0} + NumW'(root_i >> 1);
    nums = {1'b0, side_i.b_n, 30'd0} + NumW'(root_i >> 1);
  end

  logic             vld_q  [QuoW];
  side_t            side_q [QuoW];
  logic [WordW-1:0] h_q    [QuoW];
  logic [WordW-1:0] remc_q [QuoW], remc_d [QuoW], rems_q [QuoW], rems_d [QuoW];
  logic [QuoW-1:0]  lowc_q [QuoW], lowc_d [QuoW], lows_q [QuoW], lows_d [QuoW];
  logic [QuoW-1:0]  quoc_q [QuoW], quoc_d [QuoW], quos_q [QuoW], quos_d [QuoW];

  always_comb begin
    logic [WordW-1:0] hv, rc, rs;
    logic [WordW:0]   rc2, rs2;
    logic [QuoW-1:0]  lc, ls, qc, qs;
    for (int k = 0; k < QuoW; k++) begin
      hv  = (k == 0) ? h0_q    : h_q[k-1];
      rc  = (k == 0) ? remc0_q : remc_q[k-1];
      rs  = (k == 0) ? rems0_q : rems_q[k-1];
      lc  = (k == 0) ? lowc0_q : lowc_q[k-1];
      ls  = (k == 0) ? lows0_q : lows_q[k-1];
      qc  = (k == 0) ? '0      : quoc_q[k-1];
      qs  = (k == 0) ? '0      : quos_q[k-1];
      rc2 = {rc, lc[QuoW-1]};
      rs2 = {rs, ls[QuoW-1]};
      lowc_d[k] = {lc[QuoW-2:0], 1'b0};
      lows_d[k] = {ls[QuoW-2:0], 1'b0};
      if (rc2 >= {1'b0, hv}) begin
        remc_d[k] = WordW'(rc2 - {1'b0, hv});
        quoc_d[k] = {qc[QuoW-2:0], 1'b1};
      end else begin
        remc_d[k] = rc2[WordW-1:0];
        quoc_d[k] = {qc[QuoW-2:0], 1'b0};
      end
      if (rs2 >= {1'b0, hv}) begin
        rems_d[k] = WordW'(rs2 - {1'b0, hv});
        quos_d[k] = {qs[QuoW-2:0], 1'b1};
      end else begin
        rems_d[k] = rs2[WordW-1:0];
        quos_d[k] = {qs[QuoW-2:0], 1'b0};
      end
    end
  end

  // Output stage: apply signs; a zero y gives the identity rotation.
  logic                    vg_q;
  side_t                   sg_q;
  logic signed [WordW-1:0] cos_d, sin_d, cos_q, sin_q;

  always_comb begin
    logic  sig_neg, xneg, yneg;
    side_t sl;
    logic [WordW-1:0] cm, sm;
    sl      = side_q[QuoW-1];
    xneg    = sl.x[WordW-1];
    yneg    = sl.y[WordW-1];
    sig_neg = sl.gt ? yneg : xneg;
    cm      = {1'b0, quoc_q[QuoW-1]};
    sm      = {1'b0, quos_q[QuoW-1]};
    cos_d   = (sig_neg ^ xneg) ? -$signed(cm) : $signed(cm);
    sin_d   = (sig_neg ^ yneg) ? -$signed(sm) : $signed(sm);
    if (sl.yzero) begin
      cos_d = OneQ30;
      sin_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vg_q <= 1'b0;
      for (int k = 0; k < QuoW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      v0_q     <= valid_i;
      vld_q[0] <= v0_q;
      for (int k = 1; k < QuoW; k++) vld_q[k] <= vld_q[k-1];
      vg_q     <= vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q      <= side_i;
      h0_q      <= root_i;
      remc0_q   <= numc[NumW-1:QuoW];
      rems0_q   <= nums[NumW-1:QuoW];
      lowc0_q   <= numc[QuoW-1:0];
      lows0_q   <= nums[QuoW-1:0];
      side_q[0] <= s0_q;
      h_q[0]    <= h0_q;
      for (int k = 1; k < QuoW; k++) begin
        side_q[k] <= side_q[k-1];
        h_q[k]    <= h_q[k-1];
      end
      for (int k = 0; k < QuoW; k++) begin
        remc_q[k] <= remc_d[k];
        rems_q[k] <= rems_d[k];
        lowc_q[k] <= lowc_d[k];
        lows_q[k] <= lows_d[k];
        quoc_q[k] <= quoc_d[k];
        quos_q[k] <= quos_d[k];
      end
      sg_q  <= side_q[QuoW-1];
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign valid_o = vg_q;
  assign side_o  = sg_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

// ===== rtl/gru_rotate.sv =====
// Rotation stages: four products, then round, saturate and output register.
module gru_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  gru_pkg::side_t      side_i,
  input  logic signed [31:0]  cos_i,
  input  logic signed [31:0]  sin_i,
  output logic                valid_o,
  output logic [31:0]         x_o,
  output logic [31:0]         y_o,
  output logic [31:0]         cos_o,
  output logic [31:0]         sin_o,
  output logic                sat_o
);
  import gru_pkg::*;

  logic                    v1_q, v2_q;
  logic signed [WordW-1:0] pc, ps, pc_q, ps_q;
  logic                    op_q, csat_q;
  logic signed [ProdW-1:0] cx_q, sy_q, sx_q, cy_q;

  assign pc = (side_i.op == OpGenerate) ? cos_i : side_i.cc;
  assign ps = (side_i.op == OpGenerate) ? sin_i : side_i.sc;

  logic signed [ProdW-1:0] vx, vy;
  logic signed [33:0]      rx, ry;
  logic                    satx, saty;
  logic [WordW-1:0]        xo_d, yo_d;

  always_comb begin
    vx   = cx_q + sy_q + (ProdW'(1) <<< (FracQ30 - 1));
    vy   = cy_q - sx_q + (ProdW'(1) <<< (FracQ30 - 1));
    rx   = vx[ProdW-1:FracQ30];
    ry   = vy[ProdW-1:FracQ30];
    satx = !((rx[33:31] == 3'b000) || (rx[33:31] == 3'b111));
    saty = !((ry[33:31] == 3'b000) || (ry[33:31] == 3'b111));
    xo_d = satx ? (rx[33] ? 32'h8000_0000 : 32'h7fff_ffff) : rx[31:0];
    yo_d = saty ? (ry[33] ? 32'h8000_0000 : 32'h7fff_ffff) : ry[31:0];
    if (op_q == OpGenerate) begin
      yo_d = '0;
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Clamping of the given cosine and sine only counts on apply.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= side_i.op;
      csat_q <= side_i.csat && (side_i.op == OpApply);
      pc_q   <= pc;
      ps_q   <= ps;
      cx_q   <= pc * side_i.x;
      sy_q   <= ps * side_i.y;
      sx_q   <= ps * side_i.x;
      cy_q   <= pc * side_i.y;
      x_o    <= xo_d;
      y_o    <= yo_d;
      cos_o  <= pc_q;
      sin_o  <= ps_q;
      sat_o  <= csat_q | satx | saty;
    end
  end

  assign valid_o = v2_q;

endmodule

// ===== rtl/givens_rotation_unit.sv =====
// Givens rotation unit top level: stream ports and pipeline hold control.
//
// Input beats on the s_axis group carry one item: tuser is the op (apply or
// generate), tdata the pair x, y (Q16.16) and cosine, sine (Q2.30). Output
// beats on the m_axis group carry x_out (or r on generate), y_out, cos_out and
// sin_out in tdata and the saturation flag in tuser.
// Apply rotates the pair by the clamped cosine and sine. Generate derives the
// cosine and sine that zero y through a 32-stage square root and a 31-stage
// two-lane divider, and returns r in x_out with y_out zero.
// Every item travels the full pipe, so the delay from input beat to output
// beat is the same for either op; one beat is taken every cycle, limited only
// by the output handshake.
// The pipe holds as one unit: while the output register holds an untaken
// beat, every stage holds and s_axis_tready is low; beats are never dropped or
// repeated. Bubbles advance whenever the output register is empty or taken.
// Reset clears all valid bits; the pipe is empty and ready right after.
module givens_rotation_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // x_in, y_in, cos_in, sin_in
  input  logic          s_axis_tuser,   // op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // x_out, y_out, cos_out, sin_out
  output logic          m_axis_tuser    // saturated
);
  import gru_pkg::*;

  logic               en;
  logic               f_valid, q_valid, d_valid;
  side_t              f_side, q_side, d_side;
  logic [63:0]        f_rad;
  logic [31:0]        q_root;
  logic signed [31:0] d_cos, d_sin;
  logic [31:0]        x_out, y_out, cos_out, sin_out;

  // Advance everything unless the output beat is stuck.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  gru_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .x_i     (s_axis_tdata[31:0]),
    .y_i     (s_axis_tdata[63:32]),
    .cos_i   (s_axis_tdata[95:64]),
    .sin_i   (s_axis_tdata[127:96]),
    .valid_o (f_valid),
    .side_o  (f_side),
    .rad_o   (f_rad)
  );

  gru_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (f_side),
    .rad_i   (f_rad),
    .valid_o (q_valid),
    .side_o  (q_side),
    .root_o  (q_root)
  );

  gru_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_valid),
    .side_i  (q_side),
    .root_i  (q_root),
    .valid_o (d_valid),
    .side_o  (d_side),
    .cos_o   (d_cos),
    .sin_o   (d_sin)
  );

  gru_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .cos_i   (d_cos),
    .sin_i   (d_sin),
    .valid_o (m_axis_tvalid),
    .x_o     (x_out),
    .y_o     (y_out),
    .cos_o   (cos_out),
    .sin_o   (sin_out),
    .sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {sin_out, cos_out, y_out, x_out};

endmodule
